// ===== sv/tcp_video_packet_classifier_defines.svh =====
// Assertion macros shared by the classifier RTL
`ifndef TCP_VIDEO_PACKET_CLASSIFIER_DEFINES_SVH
`define TCP_VIDEO_PACKET_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

`define TVPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvpc: same-cycle check failed");

`define TVPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvpc: next-cycle check failed");

`define TVPC_ASSERT_AFTER2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("tvpc: two-cycle latency check failed");

`else

`define TVPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TVPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define TVPC_ASSERT_AFTER2(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/tvpc_pkg.sv =====
// Shared types, constants and match-string tables for the packet classifier
package tvpc_pkg;

    localparam int unsigned FRAME_LENGTH_LIMIT_DEFAULT = 65535;
    localparam int unsigned QUEUE_DEPTH_DEFAULT        = 4;

    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 88;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_PREFIX_FIRST  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PREFIX_SECOND = 1'd1;

    localparam logic [7:0] PREFIX_FIRST_RESET  = 8'h00;
    localparam logic [7:0] PREFIX_SECOND_RESET = 8'h24;

    localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

    localparam int unsigned STATUS_LEN = 28;
    localparam int unsigned VIDEO_LEN  = 20;

    localparam logic [8*STATUS_LEN-1:0] STATUS_TEXT = "HTTP/1.1 206 Partial Content";
    localparam logic [8*VIDEO_LEN-1:0]  VIDEO_TEXT  = "Content-Type: video/";

    // One queued result: a frame verdict or a tick marker
    typedef struct packed {
        logic        kind;
        logic        up;
        logic        tcp;
        logic        partial;
        logic        video;
        logic [15:0] len;
    } t_rec;

    function automatic logic [7:0] status_char(input logic [4:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (idx < 5'(STATUS_LEN)) begin
            c = STATUS_TEXT[8*(STATUS_LEN-1-int'(idx)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] video_char(input logic [4:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (idx < 5'(VIDEO_LEN)) begin
            c = VIDEO_TEXT[8*(VIDEO_LEN-1-int'(idx)) +: 8];
        end
        return c;
    endfunction

endpackage

// ===== sv/tvpc_front.sv =====
// Front end: header parsing, string matching and verdict per frame byte
module tvpc_front #(
    parameter int unsigned FRAME_LENGTH_LIMIT = tvpc_pkg::FRAME_LENGTH_LIMIT_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tvpc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [tvpc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_kind,
    input  logic [7:0]                          i_data,
    input  logic                                i_last,
    output logic                                o_rec_valid,
    output tvpc_pkg::t_rec                      o_rec,
    input  logic                                i_rec_ready
);

    localparam logic [15:0] LimitPos = 16'(FRAME_LENGTH_LIMIT);

    logic [7:0]  r_pref0, r_pref1;
    logic [15:0] r_pos,   n_pos;
    logic [7:0]  r_first, n_first;
    logic        r_up,    n_up;
    logic [3:0]  r_ihl,   n_ihl;
    logic [7:0]  r_ps,    n_ps;
    logic        r_tcp,   n_tcp;
    logic        r_ok,    n_ok;
    logic [11:0] r_sm,    n_sm;
    logic [18:0] r_vm,    n_vm;
    logic        r_vseen, n_vseen;
    logic [15:0] r_vend,  n_vend;

    logic        w_acc, w_byte, w_take, w_end;
    logic [6:0]  w_q;
    logic        w_at_q, w_in_status, w_q_ok, w_vhit;
    logic [7:0]  w_ps_new;
    logic [15:0] w_diff;
    logic [12:0] w_sm_n;
    logic [19:0] w_vm_n;
    logic [6:0]  w_q_final;
    logic        w_up_v, w_tcp_v, w_partial_v, w_video_v;

    assign o_ready = i_rec_ready;
    assign w_acc   = i_valid && i_rec_ready;
    assign w_byte  = w_acc && !i_kind;
    assign w_take  = w_byte && (r_pos < LimitPos);
    assign w_end   = w_byte && i_last;

    assign w_q         = 7'd26 + {1'b0, r_ihl, 2'b00};
    assign w_at_q      = (r_pos == {9'd0, w_q});
    assign w_ps_new    = 8'd14 + {2'b00, r_ihl, 2'b00} + {2'b00, i_data[7:4], 2'b00};
    assign w_diff      = r_pos - {8'd0, r_ps};
    assign w_in_status = (r_pos > {9'd0, w_q}) && (r_pos >= {8'd0, r_ps}) &&
                         (w_diff < 16'(tvpc_pkg::STATUS_LEN));

    // Shift-and matchers: bit j means the last j+1 bytes equal the string head
    always_comb begin
        w_sm_n[0] = (i_data == tvpc_pkg::status_char(5'd0));
        for (int j = 1; j < 13; j++) begin
            w_sm_n[j] = r_sm[j-1] && (i_data == tvpc_pkg::status_char(5'(j)));
        end
        w_vm_n[0] = (i_data == tvpc_pkg::video_char(5'd0));
        for (int j = 1; j < 20; j++) begin
            w_vm_n[j] = r_vm[j-1] && (i_data == tvpc_pkg::video_char(5'(j)));
        end
    end

    assign w_vhit = w_vm_n[19];
    // Payload at or before the offset byte: the held bytes must already match
    assign w_q_ok = (i_data[7:4] > 4'd3) || w_sm_n[4'd12 - {i_data[5:4], 2'b00}];

    always_comb begin
        n_pos   = r_pos;
        n_first = r_first;
        n_up    = r_up;
        n_ihl   = r_ihl;
        n_ps    = r_ps;
        n_tcp   = r_tcp;
        n_ok    = r_ok;
        n_sm    = r_sm;
        n_vm    = r_vm;
        n_vseen = r_vseen;
        n_vend  = r_vend;
        if (w_take) begin
            n_pos = r_pos + 16'd1;
            n_sm  = w_sm_n[11:0];
            n_vm  = w_vm_n[18:0];
            if (r_pos == 16'd0) begin
                n_first = i_data;
            end
            if (r_pos == 16'd1) begin
                n_up = (r_first == r_pref0) && (i_data == r_pref1);
            end
            if (r_pos == 16'd14) begin
                n_ihl = i_data[3:0];
            end
            if (r_pos == 16'd23) begin
                n_tcp = (i_data == 8'd6);
            end
            if (w_at_q) begin
                n_ps = w_ps_new;
                n_ok = r_ok && w_q_ok;
            end else if (w_in_status) begin
                n_ok = r_ok && (i_data == tvpc_pkg::status_char(w_diff[4:0]));
            end
            if (!r_vseen && w_vhit) begin
                n_vseen = 1'b1;
                n_vend  = r_pos + 16'd1;
            end
        end
    end

    // Verdict from the state as it stands after this byte
    assign w_q_final   = 7'd26 + {1'b0, n_ihl, 2'b00};
    assign w_up_v      = (n_pos >= 16'd2) && n_up;
    assign w_tcp_v     = (n_pos >= 16'd24) && n_tcp;
    assign w_partial_v = w_tcp_v && (n_pos > {9'd0, w_q_final}) && n_ok &&
                         ({1'b0, n_pos} >= ({9'd0, n_ps} + 17'd28));
    assign w_video_v   = w_partial_v && (n_pos >= 16'd22) && n_vseen &&
                         (({1'b0, n_vend} + 17'd2) <= {1'b0, n_pos});

    assign o_rec_valid = i_valid && (i_kind || i_last);

    always_comb begin
        o_rec = '0;
        if (i_kind) begin
            o_rec.kind = 1'b1;
        end else begin
            o_rec.up      = w_up_v;
            o_rec.tcp     = w_tcp_v;
            o_rec.partial = w_partial_v;
            o_rec.video   = w_video_v;
            o_rec.len     = n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pref0 <= tvpc_pkg::PREFIX_FIRST_RESET;
            r_pref1 <= tvpc_pkg::PREFIX_SECOND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tvpc_pkg::REG_PREFIX_FIRST:  r_pref0 <= i_cfg_wdata;
                tvpc_pkg::REG_PREFIX_SECOND: r_pref1 <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_end) begin
            r_pos   <= '0;
            r_first <= '0;
            r_up    <= 1'b0;
            r_ihl   <= '0;
            r_ps    <= '0;
            r_tcp   <= 1'b0;
            r_ok    <= 1'b1;
            r_sm    <= '0;
            r_vm    <= '0;
            r_vseen <= 1'b0;
            r_vend  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_first <= n_first;
            r_up    <= n_up;
            r_ihl   <= n_ihl;
            r_ps    <= n_ps;
            r_tcp   <= n_tcp;
            r_ok    <= n_ok;
            r_sm    <= n_sm;
            r_vm    <= n_vm;
            r_vseen <= n_vseen;
            r_vend  <= n_vend;
        end
    end

endmodule

// ===== sv/tvpc_fifo.sv =====
// Small result queue between the front end and the back end
module tvpc_fifo #(
    parameter int unsigned WIDTH = $bits(tvpc_pkg::t_rec),
    parameter int unsigned DEPTH = tvpc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== sv/tvpc_back.sv =====
// Back end: per-direction byte counters and the registered result stage
module tvpc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rec_valid,
    input  tvpc_pkg::t_rec                    i_rec,
    output logic                              o_rec_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tvpc_pkg::M_TDATA_W-1:0]    o_tdata,
    output logic                              o_tuser
);

    logic        r_valid;
    logic        r_kind, r_up, r_tcp, r_partial, r_video;
    logic [15:0] r_len;
    logic [30:0] r_up_rate, r_dn_rate;
    logic [30:0] r_up_cnt, n_up_cnt;
    logic [30:0] r_dn_cnt, n_dn_cnt;
    logic        w_load;
    logic [31:0] w_sum;
    logic [30:0] w_sat;

    assign w_load    = !r_valid || i_ready;
    assign o_rec_pop = w_load && i_rec_valid;

    // Saturating add of the frame length to the counter of its direction
    assign w_sum = {1'b0, (i_rec.up ? r_up_cnt : r_dn_cnt)} + {16'd0, i_rec.len};
    assign w_sat = (w_sum > {1'b0, tvpc_pkg::COUNT_MAX}) ? tvpc_pkg::COUNT_MAX : w_sum[30:0];

    always_comb begin
        n_up_cnt = r_up_cnt;
        n_dn_cnt = r_dn_cnt;
        if (o_rec_pop) begin
            if (i_rec.kind) begin
                n_up_cnt = '0;
                n_dn_cnt = '0;
            end else if (i_rec.up) begin
                n_up_cnt = w_sat;
            end else begin
                n_dn_cnt = w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_up_cnt <= '0;
            r_dn_cnt <= '0;
        end else begin
            if (w_load) begin
                r_valid <= i_rec_valid;
            end
            r_up_cnt <= n_up_cnt;
            r_dn_cnt <= n_dn_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_kind    <= i_rec.kind;
            r_up      <= i_rec.up;
            r_tcp     <= i_rec.tcp;
            r_partial <= i_rec.partial;
            r_video   <= i_rec.video;
            r_len     <= i_rec.len;
            r_up_rate <= i_rec.kind ? r_up_cnt : '0;
            r_dn_rate <= i_rec.kind ? r_dn_cnt : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_tuser = r_kind;
    assign o_tdata = {6'd0, r_dn_rate, r_up_rate, r_len, r_video, r_partial, r_tcp, r_up};

endmodule

// ===== sv/tcp_video_packet_classifier.sv =====
// Top level of the TCP video packet classifier
//
// Input stream: one item per transfer. tuser = 0 carries one captured Ethernet
// frame byte in tdata, with tlast on the final byte of the frame; tuser = 1 is
// a one-second tick. Output stream: one result per frame (on its last byte)
// and one per tick. tuser = 0 is a frame verdict (direction, TCP, HTTP 206,
// video content type, frame length); tuser = 1 is a byte-rate report that
// returns both direction counters and clears them.
// Throughput: one item per clock while the queue is not full; parsing and
// matching run on each byte as it arrives. A result goes into the queue at
// the edge that accepts its item and from there into the output register.
// The queue holds QUEUE_DEPTH results and the output register one more; while
// the receiver stalls they fill and s_axis_tready drops while the queue is
// full, so every input transfer waits, frame bytes that cause no result too.
// Reset (synchronous, active low) clears frame state, counters and the queue
// and loads the prefix registers with 0x00 and 0x24. The user must write the
// prefix registers through i_cfg_we / i_cfg_addr / i_cfg_wdata only while
// the block is idle; the block itself does not enforce this.
module tcp_video_packet_classifier #(
    parameter int unsigned FRAME_LENGTH_LIMIT = tvpc_pkg::FRAME_LENGTH_LIMIT_DEFAULT,
    parameter int unsigned QUEUE_DEPTH        = tvpc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tvpc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [tvpc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] data_byte
    input  logic [tvpc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] kind
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] is_upstream, [1] is_tcp, [2] is_partial_content, [3] is_video,
    // [19:4] frame_length, [50:20] upstream_rate, [81:51] downstream_rate
    output logic [tvpc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [0] report_kind
    output logic                              m_axis_tuser
);

    `include "tcp_video_packet_classifier_defines.svh"

    tvpc_pkg::t_rec w_front_rec, w_queue_rec;
    logic           w_front_valid, w_queue_full, w_queue_empty, w_queue_pop;

    tvpc_front #(
        .FRAME_LENGTH_LIMIT(FRAME_LENGTH_LIMIT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_rec_valid (w_front_valid),
        .o_rec       (w_front_rec),
        .i_rec_ready (!w_queue_full)
    );

    tvpc_fifo #(
        .WIDTH($bits(tvpc_pkg::t_rec)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_rec),
        .o_full  (w_queue_full),
        .i_pop   (w_queue_pop),
        .o_data  (w_queue_rec),
        .o_empty (w_queue_empty)
    );

    tvpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!w_queue_empty),
        .i_rec       (w_queue_rec),
        .o_rec_pop   (w_queue_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser)
    );

    `TVPC_ASSERT_IMPLY(a_video_needs_partial, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser && m_axis_tdata[3], m_axis_tdata[2] && m_axis_tdata[1])
    `TVPC_ASSERT_IMPLY(a_verdict_shape, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser,
        (m_axis_tdata[81:20] == '0) && (m_axis_tdata[19:4] != '0))
    `TVPC_ASSERT_NEXT(a_accept_fills_queue, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && (s_axis_tuser || s_axis_tlast), !w_queue_empty)
    `TVPC_ASSERT_AFTER2(a_tick_latency, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tuser && w_queue_empty && !m_axis_tvalid,
        m_axis_tvalid && m_axis_tuser)

endmodule

// ===== verif/tb_tcp_video_packet_classifier.sv =====
// Self-checking bench: byte-stream frames and ticks against a cycle-free classifier predictor
module tb_tcp_video_packet_classifier;

    localparam int CLK_PERIOD    = 10;
    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int ITEM_BUDGET   = 1550;
    localparam int RANDOM_FRAMES = 3;

    localparam int unsigned FRAME_LIMIT   = tvpc_pkg::FRAME_LENGTH_LIMIT_DEFAULT;
    localparam int unsigned STATUS_CHARS  = tvpc_pkg::STATUS_LEN;
    localparam int unsigned VIDEO_CHARS   = tvpc_pkg::VIDEO_LEN;
    localparam int unsigned WIN_LEN       = 20;

    localparam bit KIND_BYTE      = 1'b0;
    localparam bit KIND_TICK      = 1'b1;
    localparam bit REPORT_VERDICT = 1'b0;
    localparam bit REPORT_RATE    = 1'b1;

    typedef struct {
        bit        kind;
        bit        up;
        bit        tcp;
        bit        partial;
        bit        video;
        bit [15:0] len;
        bit [30:0] up_rate;
        bit [30:0] dn_rate;
    } t_verdict;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_we      = 1'b0;
    logic [tvpc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [tvpc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [tvpc_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                             s_axis_tuser  = 1'b0;
    logic                             s_axis_tlast  = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [tvpc_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                             m_axis_tuser;

    string status_str = "HTTP/1.1 206 Partial Content";
    string video_str  = "Content-Type: video/";

    // classifier state tracked by the bench
    bit [7:0]    pfx_first  = tvpc_pkg::PREFIX_FIRST_RESET;
    bit [7:0]    pfx_second = tvpc_pkg::PREFIX_SECOND_RESET;
    int unsigned byte_pos;
    bit [7:0]    first_hold;
    int unsigned ip_hdr_len;
    int unsigned payload_at;
    bit          tcp_proto;
    bit          status_clean;
    bit [7:0]    tail_win[WIN_LEN];
    int unsigned video_end;
    bit          video_found;
    bit          dir_up;
    bit [30:0]   up_bytes   = '0;
    bit [30:0]   down_bytes = '0;

    t_verdict    verdicts_due[$];
    bit [7:0]    frame_buf[$];

    bit          idle_on      = 1'b1;
    int          hold_orders  = 0;
    int          hold_served  = 0;
    int          hold_left    = 0;
    int          errors       = 0;
    int          results_seen = 0;
    int          items_sent   = 0;
    int          quiet_cycles = 0;

    tcp_video_packet_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic void clear_frame_state();
        byte_pos     = 0;
        first_hold   = '0;
        ip_hdr_len   = 0;
        payload_at   = 0;
        tcp_proto    = 1'b0;
        status_clean = 1'b1;
        foreach (tail_win[i]) tail_win[i] = '0;
        video_end    = 0;
        video_found  = 1'b0;
        dir_up       = 1'b0;
    endfunction

    function automatic bit [30:0] add_capped(bit [30:0] acc, int unsigned len);
        longint unsigned sum;
        sum = longint'(acc) + len;
        return (sum > tvpc_pkg::COUNT_MAX) ? tvpc_pkg::COUNT_MAX : sum[30:0];
    endfunction

    function automatic void absorb_byte(int unsigned p, bit [7:0] b);
        int unsigned q;
        bit          hit;
        for (int i = 0; i < WIN_LEN - 1; i++) tail_win[i] = tail_win[i + 1];
        tail_win[WIN_LEN - 1] = b;

        if (p == 0) first_hold = b;
        if (p == 1) dir_up = (first_hold == pfx_first) && (b == pfx_second);
        if (p == 14) ip_hdr_len = {b[3:0], 2'b00};
        if (p == 23) tcp_proto = (b == 8'd6);

        // TCP data offset byte: the status line may already be partly held
        q = 26 + ip_hdr_len;
        if (p == q) begin
            payload_at = q - 12 + {b[7:4], 2'b00};
            for (int unsigned k = payload_at; k <= p; k++) begin
                if (tail_win[WIN_LEN - 1 - (p - k)] != 8'(status_str[k - payload_at]))
                    status_clean = 1'b0;
            end
        end else if (p > q && p >= payload_at && p - payload_at < STATUS_CHARS) begin
            if (b != 8'(status_str[p - payload_at])) status_clean = 1'b0;
        end

        if (!video_found && p >= VIDEO_CHARS - 1) begin
            hit = 1'b1;
            for (int i = 0; i < VIDEO_CHARS; i++) begin
                if (tail_win[i] != 8'(video_str[i])) hit = 1'b0;
            end
            if (hit) begin
                video_found = 1'b1;
                video_end   = p + 1;
            end
        end
    endfunction

    function automatic void classify_item(bit kind, bit [7:0] d, bit last);
        t_verdict    v;
        int unsigned len;
        v = '{default: 0};
        if (kind == KIND_TICK) begin
            v.kind    = REPORT_RATE;
            v.up_rate = up_bytes;
            v.dn_rate = down_bytes;
            up_bytes   = '0;
            down_bytes = '0;
            verdicts_due.push_back(v);
        end else begin
            // drop bytes past the length limit
            if (byte_pos < FRAME_LIMIT) begin
                absorb_byte(byte_pos, d);
                byte_pos++;
            end
            if (last) begin
                len       = byte_pos;
                v.kind    = REPORT_VERDICT;
                v.up      = (len >= 2) && dir_up;
                v.tcp     = (len >= 24) && tcp_proto;
                v.partial = v.tcp && (len > 26 + ip_hdr_len) && status_clean &&
                            (len >= payload_at + STATUS_CHARS);
                v.video   = v.partial && (len >= 22) && video_found && (video_end + 2 <= len);
                v.len     = len[15:0];
                if (v.up) up_bytes = add_capped(up_bytes, len);
                else down_bytes = add_capped(down_bytes, len);
                verdicts_due.push_back(v);
                clear_frame_state();
            end
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_item(bit kind, bit [7:0] d, bit last);
        while (idle_on && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        classify_item(kind, d, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 8'($urandom), 1'($urandom));
    endtask

    // tick_pm: chance per thousand of a tick ahead of each byte
    task automatic send_frame(int unsigned tick_pm);
        foreach (frame_buf[i]) begin
            if ($urandom_range(0, 999) < tick_pm) send_tick();
            send_item(KIND_BYTE, frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // hold valid low until every result is back and the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [tvpc_pkg::CFG_ADDR_W-1:0] addr, bit [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        if (addr == tvpc_pkg::REG_PREFIX_FIRST) pfx_first = val;
        else pfx_second = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- frame building

    function automatic void place_byte(int unsigned at, bit [7:0] v);
        if (at < frame_buf.size()) frame_buf[at] = v;
    endfunction

    // flaw: index of a corrupted status character, -1 for none
    // vid_at: start of the video content type, -1 for none
    function automatic void build_frame(int unsigned ihl_n, int unsigned doff, bit to_up,
                                        bit [7:0] proto, int flaw, int vid_at,
                                        int unsigned total);
        int unsigned q;
        int unsigned ps;
        frame_buf.delete();
        repeat (total) frame_buf.push_back(8'($urandom));
        q  = 26 + 4 * ihl_n;
        ps = q - 12 + 4 * doff;
        if (to_up) begin
            place_byte(0, pfx_first);
            place_byte(1, pfx_second);
        end
        place_byte(14, {4'($urandom), 4'(ihl_n)});
        place_byte(23, proto);
        place_byte(q, {4'(doff), 4'($urandom)});
        for (int k = 0; k < STATUS_CHARS; k++) begin
            place_byte(ps + k, 8'(status_str[k]) ^
                       ((k == flaw) ? 8'($urandom_range(1, 255)) : 8'h00));
        end
        if (vid_at >= 0) begin
            for (int k = 0; k < VIDEO_CHARS; k++) place_byte(vid_at + k, 8'(video_str[k]));
        end
    endfunction

    task automatic random_frame();
        int unsigned sel;
        int unsigned n;
        int unsigned d;
        int unsigned ps;
        int unsigned len;
        int          vid;
        int          flaw;
        bit [7:0]    proto;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            build_frame(5, 5, 1'($urandom), 8'd6, -1, -1, $urandom_range(1, 40));
        end else if (sel < 40) begin
            frame_buf.delete();
            repeat ($urandom_range(2, 150)) frame_buf.push_back(8'($urandom));
        end else begin
            n = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
            sel = $urandom_range(0, 9);
            d = (sel < 7) ? 5 : (sel == 7) ? 2 : $urandom_range(0, 15);
            ps = 14 + 4 * n + 4 * d;
            len = ps + STATUS_CHARS;
            vid = -1;
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                vid = ps + STATUS_CHARS + $urandom_range(0, 6);
                len = vid + VIDEO_CHARS;
            end else if (sel == 7) begin
                vid = $urandom_range(0, ps + 8);
                if (vid + VIDEO_CHARS > len) len = vid + VIDEO_CHARS;
            end
            len += $urandom_range(0, 4);
            if ($urandom_range(0, 99) < 15) len = $urandom_range(1, len);
            proto = ($urandom_range(0, 99) < 85) ? 8'd6 : 8'($urandom);
            flaw  = ($urandom_range(0, 99) < 85) ? -1 : $urandom_range(0, STATUS_CHARS - 1);
            build_frame(n, d, 1'($urandom), proto, flaw, vid, len);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_defaults();
        send_tick();
        frame_buf = '{8'h00, 8'h24, 8'hA5};
        send_frame(0);
        frame_buf = '{8'h00};
        send_frame(0);
        frame_buf = '{8'hFF, 8'h24};
        send_frame(0);
        send_item(KIND_TICK, 8'hFF, 1'b1);
    endtask

    task automatic test_prefix_regs();
        settle();
        write_reg(tvpc_pkg::REG_PREFIX_FIRST, 8'hFF);
        write_reg(tvpc_pkg::REG_PREFIX_SECOND, 8'hFF);
        frame_buf = '{8'hFF, 8'hFF, 8'h00};
        send_frame(0);
        frame_buf = '{8'hFF, 8'h24};
        send_frame(0);
        settle();
        write_reg(tvpc_pkg::REG_PREFIX_FIRST, 8'h00);
        write_reg(tvpc_pkg::REG_PREFIX_SECOND, 8'h00);
        frame_buf = '{8'h00, 8'h00};
        send_frame(0);
        frame_buf = '{8'h00, 8'h01, 8'h7E};
        send_frame(0);
        send_tick();
        settle();
        write_reg(tvpc_pkg::REG_PREFIX_FIRST, 8'h3C);
        write_reg(tvpc_pkg::REG_PREFIX_SECOND, 8'hC3);
    endtask

    task automatic test_protocol_cases();
        // run this whole stretch with no idling on either side
        idle_on = 1'b0;
        // standard headers put the payload at byte 54 and the video type at 82
        build_frame(5, 5, 1'b1, 8'd6, -1, 82, 104);
        send_frame(0);
        build_frame(5, 5, 1'b0, 8'd6, -1, 82, 103);
        send_frame(0);
        build_frame(5, 5, 1'b0, 8'd6, -1, 82, 102);
        send_frame(0);
        build_frame(5, 2, 1'b1, 8'd6, -1, 70, 92);
        send_frame(0);
        build_frame(5, 5, 1'b0, 8'd6, STATUS_CHARS - 1, 82, 104);
        send_frame(0);
        build_frame(5, 5, 1'b0, 8'd6, 0, -1, 90);
        send_frame(0);
        build_frame(5, 5, 1'b0, 8'd17, -1, 82, 104);
        send_frame(0);
        build_frame(0, 5, 1'b1, 8'd6, -1, -1, 62);
        send_frame(0);
        build_frame(15, 15, 1'b1, 8'd6, -1, 162, 184);
        send_frame(0);
        build_frame(5, 0, 1'b0, 8'd6, -1, -1, 70);
        send_frame(0);
        // frames cut short of the status line, the offset byte, the protocol byte
        build_frame(5, 5, 1'b0, 8'd6, -1, -1, 81);
        send_frame(0);
        build_frame(5, 5, 1'b1, 8'd6, -1, -1, 46);
        send_frame(0);
        build_frame(5, 5, 1'b1, 8'd6, -1, -1, 23);
        send_frame(0);
        build_frame(5, 5, 1'b1, 8'd6, -1, -1, 24);
        send_frame(0);
        build_frame(5, 5, 1'b0, 8'd6, -1, 0, 22);
        send_frame(0);
        build_frame(5, 5, 1'b0, 8'd6, -1, 0, 21);
        send_frame(0);
        send_tick();
        idle_on = 1'b1;
    endtask

    task automatic test_tick_in_frame();
        build_frame(5, 5, 1'b1, 8'd6, -1, 84, 106);
        send_frame(100);
        build_frame(5, 5, 1'b0, 8'd6, -1, 82, 104);
        send_frame(60);
        send_tick();
    endtask

    task automatic test_backpressure();
        hold_orders++;
        repeat (40) begin
            if ($urandom_range(0, 1) != 0) send_tick();
            else send_item(KIND_BYTE, 8'($urandom), 1'b1);
        end
        settle();
    endtask

    task automatic test_random_traffic();
        int frames;
        frames = 0;
        while (items_sent < ITEM_BUDGET || frames < RANDOM_FRAMES) begin
            if (frames == 1) begin
                settle();
                write_reg(tvpc_pkg::REG_PREFIX_FIRST,
                          ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
                write_reg(tvpc_pkg::REG_PREFIX_SECOND,
                          ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
            end
            if ($urandom_range(0, 99) < 20) send_tick();
            random_frame();
            send_frame(10);
            frames++;
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic flag_error(string what, longint unsigned got, longint unsigned want);
        if (errors < 100)
            $display("mismatch at result %0d: %s = 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (verdicts_due.size() == 0) begin
                flag_error("unexpected transfer, tdata", m_axis_tdata[63:0], 0);
            end else begin
                want = verdicts_due.pop_front();
                if (m_axis_tuser !== want.kind)
                    flag_error("report_kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[0] !== want.up)
                    flag_error("is_upstream", m_axis_tdata[0], want.up);
                if (m_axis_tdata[1] !== want.tcp)
                    flag_error("is_tcp", m_axis_tdata[1], want.tcp);
                if (m_axis_tdata[2] !== want.partial)
                    flag_error("is_partial_content", m_axis_tdata[2], want.partial);
                if (m_axis_tdata[3] !== want.video)
                    flag_error("is_video", m_axis_tdata[3], want.video);
                if (m_axis_tdata[19:4] !== want.len)
                    flag_error("frame_length", m_axis_tdata[19:4], want.len);
                if (m_axis_tdata[50:20] !== want.up_rate)
                    flag_error("upstream_rate", m_axis_tdata[50:20], want.up_rate);
                if (m_axis_tdata[81:51] !== want.dn_rate)
                    flag_error("downstream_rate", m_axis_tdata[81:51], want.dn_rate);
                if (m_axis_tdata[tvpc_pkg::M_TDATA_W-1:82] !== '0)
                    flag_error("tdata padding", m_axis_tdata[tvpc_pkg::M_TDATA_W-1:82], 0);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_served != hold_orders) begin
            hold_served = hold_orders;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 20);
        end
    end

    // end the run if no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_tcp_video_packet_classifier: errors");
            $finish;
        end
    end

    initial begin
        clear_frame_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_defaults();
        test_prefix_regs();
        test_protocol_cases();
        test_tick_in_frame();
        test_backpressure();
        test_random_traffic();
        settle();

        if (errors == 0)
            $display("tb_tcp_video_packet_classifier: clean");
        else
            $display("tb_tcp_video_packet_classifier: errors");
        $finish;
    end

endmodule
